### sv/char_lcd_command_sequencer_assert.svh
// Assertion macros shared by the character LCD sequencer modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define CLCD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/clcd_pkg.sv
// Types and constants of the character LCD command sequencer.
// Used by the front end, the request queue, the back end and the top level.
package clcd_pkg;

    // Request kinds as they arrive on the input stream
    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_CLEAR  = 3'd1;
    localparam logic [2:0] REQ_GOTO   = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_STRING = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUNCTION_SET    = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_CONTROL = 2'd1;
    localparam logic [1:0] CFG_ENTRY_MODE      = 2'd2;
    localparam logic [1:0] CFG_SECOND_ROW_BASE = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_FUNCTION_SET    = 8'h38;
    localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0F;
    localparam logic [7:0] RST_ENTRY_MODE      = 8'h04;
    localparam logic [6:0] RST_SECOND_ROW_BASE = 7'h40;

    // LCD command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_HOME     = 8'h80;

    // Timing of a transaction in microseconds
    localparam logic [3:0]  WAIT_POLL_US  = 4'd8;
    localparam logic [10:0] WAIT_CMD_US   = 11'd39;
    localparam logic [10:0] WAIT_DATA_US  = 11'd43;
    localparam logic [10:0] WAIT_CLEAR_US = 11'd2000;

    localparam logic [4:0] MAX_COLUMN = 5'd20;

    // Classified operation handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_INIT,
        OP_CLEAR,
        OP_GOTO,
        OP_WRITE,
        OP_STRING_HOME
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;   // goto command byte or character
    } t_req;

    typedef struct packed {
        logic [7:0] function_set;
        logic [7:0] display_control;
        logic [7:0] entry_mode;
        logic [6:0] second_row_base;
    } t_cfg;

    typedef struct packed {
        logic        reg_select;
        logic [7:0]  bus_byte;
        logic        poll_busy;
        logic [3:0]  pre_wait_us;
        logic [10:0] post_wait_us;
        logic        last;
    } t_txn;

endpackage

### sv/clcd_front.sv
// Front end: accepts display requests, drops unknown kinds and classifies the rest.
// Computes the set-address byte for goto requests. Depends on clcd_pkg.
module clcd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [2:0]           i_req_type,
    input  logic [7:0]           i_char_code,
    input  logic [4:0]           i_column,
    input  logic [1:0]           i_row,
    input  logic                 i_first_of_string,
    input  logic [6:0]           i_second_row_base,
    output logic                 o_push,
    output clcd_pkg::t_req       o_push_req,
    input  logic                 i_queue_ready
);

    logic           r_valid;
    clcd_pkg::t_req r_req;
    clcd_pkg::t_req n_req;
    logic           n_known;
    logic [4:0]     w_col;
    logic [6:0]     w_addr;
    logic           w_accept;

    // Clamp the column and form the display address
    always_comb begin
        if (i_column == 5'd0) begin
            w_col = 5'd1;
        end else if (i_column > clcd_pkg::MAX_COLUMN) begin
            w_col = clcd_pkg::MAX_COLUMN;
        end else begin
            w_col = i_column;
        end
        w_addr = {2'b00, w_col - 5'd1} + (i_row[1] ? i_second_row_base : 7'd0);
    end

    // Classify the request
    always_comb begin
        n_known  = 1'b1;
        n_req.op = clcd_pkg::OP_WRITE;
        n_req.data = i_char_code;
        case (i_req_type)
            clcd_pkg::REQ_INIT:  n_req.op = clcd_pkg::OP_INIT;
            clcd_pkg::REQ_CLEAR: n_req.op = clcd_pkg::OP_CLEAR;
            clcd_pkg::REQ_GOTO: begin
                n_req.op   = clcd_pkg::OP_GOTO;
                n_req.data = clcd_pkg::CMD_SET_ADDR | {1'b0, w_addr};
            end
            clcd_pkg::REQ_WRITE: n_req.op = clcd_pkg::OP_WRITE;
            clcd_pkg::REQ_STRING: begin
                n_req.op = i_first_of_string ? clcd_pkg::OP_STRING_HOME
                                             : clcd_pkg::OP_WRITE;
            end
            default: n_known = 1'b0;
        endcase
    end

    assign o_req_ready = !r_valid || i_queue_ready;
    assign w_accept    = i_req_valid && o_req_ready;
    assign o_push      = r_valid && i_queue_ready;
    assign o_push_req  = r_req;

    // Hold one classified request until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= n_known;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= n_req;
        end
    end

endmodule

### sv/clcd_queue.sv
// Short request queue between the front end and the back end.
// Holds classified requests (clcd_pkg::t_req); uses the shared assertion macros.
`include "char_lcd_command_sequencer_assert.svh"

module clcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clcd_pkg::t_req i_push_req,
    output logic           o_ready,
    output logic           o_valid,
    output clcd_pkg::t_req o_req,
    input  logic           i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    clcd_pkg::t_req   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    `CLCD_ASSERT_ALWAYS(a_queue_no_overflow, !(i_push && !o_ready), "push into full queue")
    `CLCD_ASSERT_ALWAYS(a_queue_no_underflow, !(i_pop && !o_valid), "pop from empty queue")

endmodule

### sv/clcd_back.sv
// Back end: expands each queued request into its LCD bus transactions.
// Drives a registered output stage; depends on clcd_pkg and the assertion macros.
`include "char_lcd_command_sequencer_assert.svh"

module clcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clcd_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  clcd_pkg::t_req i_q_req,
    output logic           o_q_pop,
    output logic           o_txn_valid,
    input  logic           i_txn_ready,
    output clcd_pkg::t_txn o_txn
);

    logic           r_out_valid;
    clcd_pkg::t_txn r_out;
    logic [1:0]     r_step;
    clcd_pkg::t_txn n_txn;
    logic           w_load;
    logic           w_stall;

    // Build the transaction for the current request and step
    always_comb begin
        n_txn.reg_select   = 1'b0;
        n_txn.bus_byte     = clcd_pkg::CMD_CLEAR;
        n_txn.poll_busy    = 1'b0;
        n_txn.post_wait_us = clcd_pkg::WAIT_CMD_US;
        n_txn.last         = 1'b1;
        case (i_q_req.op)
            clcd_pkg::OP_INIT: begin
                n_txn.last = (r_step == 2'd3);
                case (r_step)
                    2'd0: begin
                        n_txn.bus_byte  = i_cfg.function_set;
                        n_txn.poll_busy = 1'b1;
                    end
                    2'd1: n_txn.bus_byte = i_cfg.display_control;
                    2'd2: n_txn.post_wait_us = clcd_pkg::WAIT_CLEAR_US;
                    default: n_txn.bus_byte = i_cfg.entry_mode;
                endcase
            end
            clcd_pkg::OP_CLEAR: n_txn.post_wait_us = clcd_pkg::WAIT_CLEAR_US;
            clcd_pkg::OP_GOTO: begin
                n_txn.bus_byte  = i_q_req.data;
                n_txn.poll_busy = 1'b1;
            end
            clcd_pkg::OP_STRING_HOME: begin
                n_txn.last = (r_step == 2'd2);
                case (r_step)
                    2'd0: n_txn.post_wait_us = clcd_pkg::WAIT_CLEAR_US;
                    2'd1: begin
                        n_txn.bus_byte  = clcd_pkg::CMD_HOME;
                        n_txn.poll_busy = 1'b1;
                    end
                    default: begin
                        n_txn.reg_select   = 1'b1;
                        n_txn.bus_byte     = i_q_req.data;
                        n_txn.poll_busy    = 1'b1;
                        n_txn.post_wait_us = clcd_pkg::WAIT_DATA_US;
                    end
                endcase
            end
            default: begin
                n_txn.reg_select   = 1'b1;
                n_txn.bus_byte     = i_q_req.data;
                n_txn.poll_busy    = 1'b1;
                n_txn.post_wait_us = clcd_pkg::WAIT_DATA_US;
            end
        endcase
        n_txn.pre_wait_us = n_txn.poll_busy ? clcd_pkg::WAIT_POLL_US : 4'd0;
    end

    assign w_load      = i_q_valid && (!r_out_valid || i_txn_ready);
    assign w_stall     = r_out_valid && !i_txn_ready;
    assign o_q_pop     = w_load && n_txn.last;
    assign o_txn_valid = r_out_valid;
    assign o_txn       = r_out;

    // Advance the step counter and the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= 2'd0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_step      <= n_txn.last ? 2'd0 : r_step + 2'd1;
        end else if (i_txn_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_txn;
        end
    end

    `CLCD_ASSERT_ALWAYS(a_step_needs_request, (r_step == 2'd0) || i_q_valid, "step w/o request")
    `CLCD_ASSERT_NEXT(a_last_restarts_step, o_q_pop, r_step == 2'd0, "step not cleared")
    `CLCD_ASSERT_NEXT(a_stall_holds_txn, w_stall, r_out_valid && $stable(r_out), "stall lost txn")

endmodule

### sv/char_lcd_command_sequencer.sv
// Character LCD command sequencer: one display request in, up to four bus
// transactions out. The front end takes one request per cycle while the queue
// has room; the back end emits one transaction per cycle while the receiver is ready,
// so a request yields one (clear, goto, write char, plain string char), three (first
// string char) or four (init) transactions. Unknown request kinds produce nothing.
// A request passes the front-end register, the queue and the back-end output register.
// The configuration port is always ready; write it only while no request is pending.
module char_lcd_command_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // char_code[7:0], column[12:8], row[14:13], zero[15]
    input  logic [3:0]  s_axis_tuser,   // req_type[2:0], first_of_string[3]
    // Transaction stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // bus_byte[7:0], poll_busy[8], pre_wait_us[12:9],
                                        // post_wait_us[23:13]
    output logic [0:0]  m_axis_tuser,   // reg_select[0]
    output logic        m_axis_tlast
);

    clcd_pkg::t_cfg r_cfg;
    logic           w_push;
    clcd_pkg::t_req w_push_req;
    logic           w_q_ready;
    logic           w_q_valid;
    clcd_pkg::t_req w_q_req;
    logic           w_q_pop;
    clcd_pkg::t_txn w_txn;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.function_set    <= clcd_pkg::RST_FUNCTION_SET;
            r_cfg.display_control <= clcd_pkg::RST_DISPLAY_CONTROL;
            r_cfg.entry_mode      <= clcd_pkg::RST_ENTRY_MODE;
            r_cfg.second_row_base <= clcd_pkg::RST_SECOND_ROW_BASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clcd_pkg::CFG_FUNCTION_SET:    r_cfg.function_set    <= i_cfg_data;
                clcd_pkg::CFG_DISPLAY_CONTROL: r_cfg.display_control <= i_cfg_data;
                clcd_pkg::CFG_ENTRY_MODE:      r_cfg.entry_mode      <= i_cfg_data;
                clcd_pkg::CFG_SECOND_ROW_BASE: r_cfg.second_row_base <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    clcd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (s_axis_tvalid),
        .o_req_ready       (s_axis_tready),
        .i_req_type        (s_axis_tuser[2:0]),
        .i_char_code       (s_axis_tdata[7:0]),
        .i_column          (s_axis_tdata[12:8]),
        .i_row             (s_axis_tdata[14:13]),
        .i_first_of_string (s_axis_tuser[3]),
        .i_second_row_base (r_cfg.second_row_base),
        .o_push            (w_push),
        .o_push_req        (w_push_req),
        .i_queue_ready     (w_q_ready)
    );

    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_req (w_push_req),
        .o_ready    (w_q_ready),
        .o_valid    (w_q_valid),
        .o_req      (w_q_req),
        .i_pop      (w_q_pop)
    );

    clcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_req     (w_q_req),
        .o_q_pop     (w_q_pop),
        .o_txn_valid (m_axis_tvalid),
        .i_txn_ready (m_axis_tready),
        .o_txn       (w_txn)
    );

    // Pack the transaction onto the output stream
    assign m_axis_tdata = {w_txn.post_wait_us, w_txn.pre_wait_us, w_txn.poll_busy,
                           w_txn.bus_byte};
    assign m_axis_tuser = w_txn.reg_select;
    assign m_axis_tlast = w_txn.last;

endmodule

### tb/sv/char_lcd_command_sequencer_tb.sv
// Self-checking testbench for the character LCD command sequencer.
// Drives display requests and register writes and predicts every bus transaction.
// Depends on clcd_pkg and char_lcd_command_sequencer only.
module char_lcd_command_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS      = 6;
    localparam int RESET_CYCLES     = 12;
    // Settling time after the last expected transaction has been seen
    localparam int SETTLE_CYCLES    = 16;
    // Longest quiet stretch allowed before the watchdog ends the run
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 30;
    localparam int NUM_PHASES       = 4;

    localparam logic       RS_COMMAND       = 1'b0;
    localparam logic       RS_DATA          = 1'b1;
    localparam logic [2:0] REQ_RESERVED_MIN = 3'd5;
    localparam logic [2:0] REQ_RESERVED_MID = 3'd6;
    localparam logic [2:0] REQ_RESERVED_MAX = 3'd7;

    // Expected LCD bus transactions, with a private copy of the registers
    class lcd_txn_tracker;
        clcd_pkg::t_cfg regs;
        clcd_pkg::t_txn pending_bus_txns[$];
        int unsigned    errors;
        int unsigned    checked;

        function new();
            regs.function_set    = clcd_pkg::RST_FUNCTION_SET;
            regs.display_control = clcd_pkg::RST_DISPLAY_CONTROL;
            regs.entry_mode      = clcd_pkg::RST_ENTRY_MODE;
            regs.second_row_base = clcd_pkg::RST_SECOND_ROW_BASE;
            errors  = 0;
            checked = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int pending_count();
            return pending_bus_txns.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] value);
            case (idx)
                clcd_pkg::CFG_FUNCTION_SET:    regs.function_set    = value;
                clcd_pkg::CFG_DISPLAY_CONTROL: regs.display_control = value;
                clcd_pkg::CFG_ENTRY_MODE:      regs.entry_mode      = value;
                clcd_pkg::CFG_SECOND_ROW_BASE: regs.second_row_base = value[6:0];
                default: ;
            endcase
        endfunction

        // Clamp the column to 1..20, add the row base, wrap within 7 bits
        function logic [7:0] set_address_byte(logic [4:0] col, logic [1:0] row);
            logic [4:0] c;
            logic [6:0] addr;
            c = col;
            if (c < 5'd1) c = 5'd1;
            if (c > clcd_pkg::MAX_COLUMN) c = clcd_pkg::MAX_COLUMN;
            addr = 7'(c - 5'd1);
            if (row >= 2'd2) addr = addr + regs.second_row_base;
            return clcd_pkg::CMD_SET_ADDR | {1'b0, addr};
        endfunction

        function void push_txn(logic rs, logic [7:0] bus_val, logic poll,
                               logic [10:0] post, logic is_last);
            clcd_pkg::t_txn t;
            t.reg_select   = rs;
            t.bus_byte     = bus_val;
            t.poll_busy    = poll;
            t.pre_wait_us  = poll ? clcd_pkg::WAIT_POLL_US : 4'd0;
            t.post_wait_us = post;
            t.last         = is_last;
            pending_bus_txns.push_back(t);
        endfunction

        // Expand one accepted request; returns the number of transactions it causes
        function int note_request(logic [2:0] kind, logic [7:0] ch, logic [4:0] col,
                                  logic [1:0] row, logic first);
            int before_size;
            before_size = pending_bus_txns.size();
            case (kind)
                clcd_pkg::REQ_INIT: begin
                    push_txn(RS_COMMAND, regs.function_set, 1'b1,
                             clcd_pkg::WAIT_CMD_US, 1'b0);
                    push_txn(RS_COMMAND, regs.display_control, 1'b0,
                             clcd_pkg::WAIT_CMD_US, 1'b0);
                    push_txn(RS_COMMAND, clcd_pkg::CMD_CLEAR, 1'b0,
                             clcd_pkg::WAIT_CLEAR_US, 1'b0);
                    push_txn(RS_COMMAND, regs.entry_mode, 1'b0,
                             clcd_pkg::WAIT_CMD_US, 1'b1);
                end
                clcd_pkg::REQ_CLEAR: begin
                    push_txn(RS_COMMAND, clcd_pkg::CMD_CLEAR, 1'b0,
                             clcd_pkg::WAIT_CLEAR_US, 1'b1);
                end
                clcd_pkg::REQ_GOTO: begin
                    push_txn(RS_COMMAND, set_address_byte(col, row), 1'b1,
                             clcd_pkg::WAIT_CMD_US, 1'b1);
                end
                clcd_pkg::REQ_WRITE: begin
                    push_txn(RS_DATA, ch, 1'b1, clcd_pkg::WAIT_DATA_US, 1'b1);
                end
                clcd_pkg::REQ_STRING: begin
                    // First character of a string: clear, then home to row one column one
                    if (first) begin
                        push_txn(RS_COMMAND, clcd_pkg::CMD_CLEAR, 1'b0,
                                 clcd_pkg::WAIT_CLEAR_US, 1'b0);
                        push_txn(RS_COMMAND, set_address_byte(5'd1, 2'd1), 1'b1,
                                 clcd_pkg::WAIT_CMD_US, 1'b0);
                    end
                    push_txn(RS_DATA, ch, 1'b1, clcd_pkg::WAIT_DATA_US, 1'b1);
                end
                default: ;
            endcase
            return pending_bus_txns.size() - before_size;
        endfunction

        // Compare one accepted transaction with the oldest expectation
        task check_bus_txn(clcd_pkg::t_txn got);
            clcd_pkg::t_txn want;
            checked++;
            if (pending_bus_txns.size() == 0) begin
                report($sformatf("unexpected transaction rs=%0d byte=%02h",
                                 got.reg_select, got.bus_byte));
                return;
            end
            want = pending_bus_txns.pop_front();
            if (got.reg_select !== want.reg_select)
                report($sformatf("reg_select %0d, expected %0d",
                                 got.reg_select, want.reg_select));
            if (got.bus_byte !== want.bus_byte)
                report($sformatf("bus_byte %02h, expected %02h", got.bus_byte, want.bus_byte));
            if (got.poll_busy !== want.poll_busy)
                report($sformatf("poll_busy %0d, expected %0d", got.poll_busy, want.poll_busy));
            if (got.pre_wait_us !== want.pre_wait_us)
                report($sformatf("pre_wait_us %0d, expected %0d",
                                 got.pre_wait_us, want.pre_wait_us));
            if (got.post_wait_us !== want.post_wait_us)
                report($sformatf("post_wait_us %0d, expected %0d",
                                 got.post_wait_us, want.post_wait_us));
            if (got.last !== want.last)
                report($sformatf("last %0d, expected %0d", got.last, want.last));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = clcd_pkg::CFG_FUNCTION_SET;
    logic [7:0]  i_cfg_data    = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'h0000;
    logic [3:0]  s_axis_tuser  = 4'h0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    lcd_txn_tracker tracker;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;
    int request_count      = 0;
    int ignored_count      = 0;

    char_lcd_command_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Stall the transaction stream at random
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Check every accepted bus transaction
    always @(posedge i_clk) begin : bus_monitor
        clcd_pkg::t_txn got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.reg_select   = m_axis_tuser[0];
            got.bus_byte     = m_axis_tdata[7:0];
            got.poll_busy    = m_axis_tdata[8];
            got.pre_wait_us  = m_axis_tdata[12:9];
            got.post_wait_us = m_axis_tdata[23:13];
            got.last         = m_axis_tlast;
            tracker.check_bus_txn(got);
        end
    end

    // End the run when no channel has moved a transaction for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one request, hold it until accepted; tvalid stays high for a follower
    task automatic send_request(input logic [2:0] kind, input logic [7:0] ch,
                                input logic [4:0] col, input logic [1:0] row,
                                input logic first);
        int produced;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {1'b0, row, col, ch};
        s_axis_tuser  = {first, kind};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        produced = tracker.note_request(kind, ch, col, row, first);
        if (produced == 0) ignored_count++;
        else request_count++;
        @(negedge i_clk);
    endtask

    // Drop the request stream and wait for every expected transaction, then settle
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (tracker.pending_count() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all four registers back to back once the block is idle
    task automatic program_registers(input logic [7:0] fs, input logic [7:0] dc,
                                     input logic [7:0] em, input logic [7:0] base);
        logic [1:0] idx[4];
        logic [7:0] val[4];
        idx = '{clcd_pkg::CFG_FUNCTION_SET, clcd_pkg::CFG_DISPLAY_CONTROL,
                clcd_pkg::CFG_ENTRY_MODE, clcd_pkg::CFG_SECOND_ROW_BASE};
        val = '{fs, dc, em, base};
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            i_cfg_index = idx[i];
            i_cfg_data  = val[i];
            i_cfg_valid = 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.set_register(idx[i], val[i]);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int idle_profile[NUM_PHASES];
        int stall_profile[NUM_PHASES];
        int sent;
        int pick;
        int burst;
        bit paused;
        logic [2:0] kind;

        idle_profile  = '{0, 64, 0, 24};
        stall_profile = '{0, 0, 64, 24};
        paused  = 1'b0;
        tracker = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every request kind at reset settings, column clamping and row selection
        send_request(clcd_pkg::REQ_INIT,   8'h00, 5'd0,  2'd0, 1'b0);
        send_request(clcd_pkg::REQ_CLEAR,  8'hFF, 5'd31, 2'd3, 1'b1);
        send_request(clcd_pkg::REQ_GOTO,   8'h00, 5'd0,  2'd0, 1'b0);
        send_request(clcd_pkg::REQ_GOTO,   8'h00, 5'd1,  2'd1, 1'b0);
        send_request(clcd_pkg::REQ_GOTO,   8'h00, 5'd20, 2'd2, 1'b0);
        send_request(clcd_pkg::REQ_GOTO,   8'hFF, 5'd21, 2'd3, 1'b1);
        send_request(clcd_pkg::REQ_GOTO,   8'h00, 5'd31, 2'd2, 1'b0);
        send_request(clcd_pkg::REQ_WRITE,  8'h00, 5'd0,  2'd0, 1'b0);
        send_request(clcd_pkg::REQ_WRITE,  8'hFF, 5'd31, 2'd3, 1'b1);
        send_request(clcd_pkg::REQ_STRING, 8'h41, 5'd7,  2'd2, 1'b1);
        send_request(clcd_pkg::REQ_STRING, 8'h5A, 5'd0,  2'd1, 1'b0);
        send_request(clcd_pkg::REQ_STRING, 8'hFF, 5'd31, 2'd3, 1'b0);
        // Reserved kinds emit nothing
        send_request(REQ_RESERVED_MIN, 8'hFF, 5'd31, 2'd3, 1'b1);
        send_request(REQ_RESERVED_MID, 8'h00, 5'd0,  2'd0, 1'b0);
        send_request(REQ_RESERVED_MAX, 8'hFF, 5'd31, 2'd3, 1'b1);

        // Directed: all registers at their low extreme
        program_registers(8'h00, 8'h00, 8'h00, 8'h00);
        send_request(clcd_pkg::REQ_INIT, 8'h00, 5'd0,  2'd0, 1'b0);
        send_request(clcd_pkg::REQ_GOTO, 8'h00, 5'd20, 2'd2, 1'b0);

        // Directed: all registers at their high extreme, address wraps in 7 bits
        program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(clcd_pkg::REQ_INIT,   8'h00, 5'd0,  2'd0, 1'b0);
        send_request(clcd_pkg::REQ_GOTO,   8'h00, 5'd20, 2'd2, 1'b0);
        send_request(clcd_pkg::REQ_GOTO,   8'h00, 5'd1,  2'd3, 1'b0);
        send_request(clcd_pkg::REQ_STRING, 8'h30, 5'd9,  2'd3, 1'b1);

        // Random: one register setting and one idle profile per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 1)
                program_registers(clcd_pkg::RST_FUNCTION_SET, clcd_pkg::RST_DISPLAY_CONTROL,
                                  clcd_pkg::RST_ENTRY_MODE,
                                  {1'b0, clcd_pkg::RST_SECOND_ROW_BASE});
            else
                program_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            sender_idle_pct    = idle_profile[p];
            receiver_stall_pct = stall_profile[p];
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    // Well-formed string: first character flagged, rest plain
                    burst = $urandom_range(1, 6);
                    for (int j = 0; j < burst; j++) begin
                        send_request(clcd_pkg::REQ_STRING, 8'($urandom), 5'($urandom),
                                     2'($urandom), j == 0);
                        sent++;
                    end
                end else if (pick < 92) begin
                    if (pick < 36)      kind = clcd_pkg::REQ_STRING;
                    else if (pick < 46) kind = clcd_pkg::REQ_INIT;
                    else if (pick < 56) kind = clcd_pkg::REQ_CLEAR;
                    else if (pick < 76) kind = clcd_pkg::REQ_GOTO;
                    else                kind = clcd_pkg::REQ_WRITE;
                    send_request(kind, 8'($urandom), 5'($urandom), 2'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    kind = 3'($urandom_range(REQ_RESERVED_MIN, REQ_RESERVED_MAX));
                    send_request(kind, 8'($urandom), 5'($urandom), 2'($urandom), 1'($urandom));
                end
                // Hold the sender once mid-phase until the block has drained
                if (p == 1 && !paused && sent >= RANDOM_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        $display("Sent %0d requests plus %0d reserved kinds, checked %0d bus transactions,",
                 request_count, ignored_count, tracker.checked);
        $display("across extreme and random register settings and four idle profiles.");
        if (tracker.errors == 0 && tracker.pending_count() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d transactions never seen",
                     tracker.errors, tracker.pending_count());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
